// ===== design/swt_pkg.sv =====
package swt_pkg;

  // Command codes carried in s_tuser
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_STOP  = 2'd2;
  localparam cmd_t CMD_LOAD  = 2'd3;

  // Field widths
  localparam int SET_HMS_W    = 7;
  localparam int SET_MILLIS_W = 10;
  localparam int HOURS_W      = 11;
  localparam int MINUTES_W    = 6;
  localparam int SECONDS_W    = 6;
  localparam int MILLIS_W     = 10;
  localparam int TPM_W        = 16;

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  // Countdown counts come only from a preset, so hours stay small there
  localparam int SAVED_HOURS_W = 8;
  localparam logic [HOURS_W-1:0] CD_HOURS_MAX = 11'd129;

  localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [MILLIS_W-1:0]  millis;
  } clock_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [SET_HMS_W-1:0]    set_hours;
    logic [SET_HMS_W-1:0]    set_minutes;
    logic [SET_HMS_W-1:0]    set_seconds;
    logic [SET_MILLIS_W-1:0] set_millis;
  } item_t;

  typedef struct packed {
    clock_t count;
    logic   is_running;
    logic   is_countdown;
    logic   alarm;
  } result_t;

  // Last digit values of the mixed-radix count
  localparam logic [MILLIS_W-1:0]  MILLIS_LAST  = 10'd999;
  localparam logic [SECONDS_W-1:0] SECONDS_LAST = 6'd59;
  localparam logic [MINUTES_W-1:0] MINUTES_LAST = 6'd59;

  // 2^32 - 1 ms: the stopwatch wraps to zero after this value
  localparam clock_t CLOCK_WRAP = {11'd1193, 6'd2, 6'd47, 10'd295};

endpackage

// ===== design/stopwatch_countdown_timer.sv =====
// Stopwatch and countdown timer with a millisecond count. Each input beat
// carries one command (tick, start, stop/clear, load preset) and produces
// exactly one output beat with the count as hours, minutes, seconds and
// milliseconds plus running, countdown and alarm flags. The count is held as
// mixed-radix digits, so no division is needed. An item enters an input
// register, is applied to the timer state and lands in a result register:
// one item per cycle sustained while the output is not stalled.
// ticks_per_ms (reset 1000, 0 acts as 1) must be written only while no beat
// is in flight; the block itself does not enforce this.
module stopwatch_countdown_timer
  import swt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [TPM_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // set_hours[6:0], set_minutes[13:7], set_seconds[20:14], set_millis[30:21]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // show_hours[10:0], show_minutes[16:11], show_seconds[22:17], show_millis[32:23]
  output logic [M_TDATA_W-1:0] m_tdata,
  // is_running[0], is_countdown[1], alarm[2]
  output logic [M_TUSER_W-1:0] m_tuser
);

  logic    in_valid;
  item_t   item;
  logic    out_space;
  logic    fire;
  result_t result;
  result_t held;

  assign fire = in_valid && out_space;

  swt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .pop      (fire),
    .valid    (in_valid),
    .item     (item)
  );

  swt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  swt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .space    (out_space),
    .held     (held)
  );

  // Pack the result beat
  assign m_tdata = {7'd0, held.count.millis, held.count.seconds,
                    held.count.minutes, held.count.hours};
  assign m_tuser = {held.alarm, held.is_countdown, held.is_running};

endmodule

// ===== design/swt_in_stage.sv =====
module swt_in_stage
  import swt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 pop,
  output logic                 valid,
  output item_t                item
);

  // Take a beat when empty or when the held item moves on this cycle
  assign s_tready = !valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Unpack the beat into the item register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd         <= s_tuser[1:0];
      item.set_hours   <= s_tdata[6:0];
      item.set_minutes <= s_tdata[13:7];
      item.set_seconds <= s_tdata[20:14];
      item.set_millis  <= s_tdata[30:21];
    end
  end

endmodule

// ===== design/swt_core.sv =====
module swt_core
  import swt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [TPM_W-1:0] cfg_wdata,
  input  logic             fire,
  input  item_t            item,
  output result_t          result
);

  localparam logic [MILLIS_W-1:0] MS_PER_SEC     = 10'd1000;
  localparam logic [7:0]          TWO_MINUTES_SEC = 8'd120;
  localparam logic [7:0]          ONE_MINUTE_SEC  = 8'd60;

  // Timer state
  logic [TPM_W-1:0]         ticks_per_ms;
  logic                     running, running_next;
  logic                     paused, paused_next;
  logic                     stopwatch_mode, stopwatch_mode_next;
  logic                     alert_flag, alert_flag_next;
  clock_t                   count, count_next;
  logic [TPM_W-1:0]         prescale, prescale_next;
  clock_t                   saved, saved_next;

  logic [TPM_W-1:0] limit;
  logic [TPM_W-1:0] prescale_inc;
  logic             count_zero;
  logic             preset_zero;
  logic             sw_start;
  clock_t           preset;

  // Step the mixed-radix count up by one ms, wrapping at 2^32 ms
  function automatic clock_t clock_inc(input clock_t c);
    clock_t r;
    r = c;
    if (c == CLOCK_WRAP) begin
      r = '0;
    end else if (c.millis != MILLIS_LAST) begin
      r.millis = c.millis + 10'd1;
    end else begin
      r.millis = '0;
      if (c.seconds != SECONDS_LAST) begin
        r.seconds = c.seconds + 6'd1;
      end else begin
        r.seconds = '0;
        if (c.minutes != MINUTES_LAST) begin
          r.minutes = c.minutes + 6'd1;
        end else begin
          r.minutes = '0;
          r.hours   = c.hours + 11'd1;
        end
      end
    end
    return r;
  endfunction

  // Step a nonzero count down by one ms with borrows
  function automatic clock_t clock_dec(input clock_t c);
    clock_t r;
    r = c;
    if (c.millis != '0) begin
      r.millis = c.millis - 10'd1;
    end else begin
      r.millis = MILLIS_LAST;
      if (c.seconds != '0) begin
        r.seconds = c.seconds - 6'd1;
      end else begin
        r.seconds = SECONDS_LAST;
        if (c.minutes != '0) begin
          r.minutes = c.minutes - 6'd1;
        end else begin
          r.minutes = MINUTES_LAST;
          r.hours   = c.hours - 11'd1;
        end
      end
    end
    return r;
  endfunction

  // Fold out-of-range preset digits into the next digit up
  function automatic clock_t preset_norm(input item_t it);
    logic       c_ms;
    logic [7:0] s_sum;
    logic [7:0] m_sum;
    logic [1:0] q_s;
    logic [1:0] q_m;
    clock_t     r;
    if (it.set_millis >= MS_PER_SEC) begin
      r.millis = it.set_millis - MS_PER_SEC;
      c_ms     = 1'b1;
    end else begin
      r.millis = it.set_millis;
      c_ms     = 1'b0;
    end
    s_sum = {1'b0, it.set_seconds} + {7'd0, c_ms};
    if (s_sum >= TWO_MINUTES_SEC) begin
      s_sum = s_sum - TWO_MINUTES_SEC;
      q_s   = 2'd2;
    end else if (s_sum >= ONE_MINUTE_SEC) begin
      s_sum = s_sum - ONE_MINUTE_SEC;
      q_s   = 2'd1;
    end else begin
      q_s   = 2'd0;
    end
    r.seconds = s_sum[SECONDS_W-1:0];
    m_sum = {1'b0, it.set_minutes} + {6'd0, q_s};
    if (m_sum >= TWO_MINUTES_SEC) begin
      m_sum = m_sum - TWO_MINUTES_SEC;
      q_m   = 2'd2;
    end else if (m_sum >= ONE_MINUTE_SEC) begin
      m_sum = m_sum - ONE_MINUTE_SEC;
      q_m   = 2'd1;
    end else begin
      q_m   = 2'd0;
    end
    r.minutes = m_sum[MINUTES_W-1:0];
    r.hours   = {4'd0, it.set_hours} + {9'd0, q_m};
    return r;
  endfunction

  assign limit        = (ticks_per_ms == '0) ? 16'd1 : ticks_per_ms;
  assign prescale_inc = prescale + 16'd1;
  assign count_zero   = (count == '0);
  assign preset_zero  = (item.set_hours == '0) && (item.set_minutes == '0) &&
                        (item.set_seconds == '0) && (item.set_millis == '0);
  assign sw_start     = stopwatch_mode || count_zero;
  assign preset       = preset_norm(item);

  // Apply one command to the timer state
  always_comb begin
    running_next        = running;
    paused_next         = paused;
    stopwatch_mode_next = stopwatch_mode;
    alert_flag_next     = alert_flag;
    count_next          = count;
    prescale_next       = prescale;
    saved_next          = saved;
    case (item.cmd)
      CMD_TICK: begin
        if (running && !alert_flag) begin
          if (prescale_inc >= limit) begin
            prescale_next = '0;
            if (stopwatch_mode) begin
              count_next = clock_inc(count);
            end else if (count_zero) begin
              alert_flag_next = 1'b1;
            end else begin
              count_next = clock_dec(count);
            end
          end else begin
            prescale_next = prescale_inc;
          end
        end
      end
      CMD_START: begin
        if (!running) begin
          prescale_next       = '0;
          stopwatch_mode_next = sw_start;
          if (sw_start) begin
            if (!paused) begin
              count_next = '0;
            end
          end else if (!paused) begin
            saved_next = count;
          end
          running_next = 1'b1;
          paused_next  = 1'b0;
        end
      end
      CMD_STOP: begin
        if (running) begin
          if (!stopwatch_mode && alert_flag) begin
            count_next = saved;
          end
          running_next = 1'b0;
          paused_next  = 1'b1;
        end else begin
          count_next          = '0;
          stopwatch_mode_next = 1'b1;
          paused_next         = 1'b0;
        end
        alert_flag_next = 1'b0;
      end
      CMD_LOAD: begin
        if (!running) begin
          paused_next = 1'b0;
          if (!preset_zero) begin
            stopwatch_mode_next = 1'b0;
            count_next          = preset;
          end else begin
            stopwatch_mode_next = 1'b1;
            count_next          = '0;
          end
        end
      end
      default: begin
        running_next = running;
      end
    endcase
  end

  // Hold the prescaler setting
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TPM_RESET;
    end else if (cfg_wen) begin
      ticks_per_ms <= cfg_wdata;
    end
  end

  // Advance the state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      paused         <= 1'b0;
      stopwatch_mode <= 1'b1;
      alert_flag     <= 1'b0;
      count          <= '0;
      prescale       <= '0;
      saved          <= '0;
    end else if (fire) begin
      running        <= running_next;
      paused         <= paused_next;
      stopwatch_mode <= stopwatch_mode_next;
      alert_flag     <= alert_flag_next;
      count          <= count_next;
      prescale       <= prescale_next;
      saved          <= {{(HOURS_W-SAVED_HOURS_W){1'b0}},
                         saved_next.hours[SAVED_HOURS_W-1:0],
                         saved_next.minutes, saved_next.seconds, saved_next.millis};
    end
  end

  assign result.count        = count_next;
  assign result.is_running   = running_next;
  assign result.is_countdown = !stopwatch_mode_next;
  assign result.alarm        = alert_flag_next;

endmodule

// ===== design/swt_out_stage.sv =====
module swt_out_stage
  import swt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t result,
  input  logic    m_tready,
  output logic    m_tvalid,
  output logic    space,
  output result_t held
);

  // Room for a new result when empty or when the held one leaves now
  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= push;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (push && space) begin
      held <= result;
    end
  end

endmodule

// ===== design/swt_checker.sv =====
module swt_checker
  import swt_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A fresh result follows an accepted beat through the input and result registers
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without an input beat");

  // Alarm only while a countdown is running
  a_alarm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1] && m_tuser[0])
    else $error("alarm outside a running countdown");

  // Digits stay in range
  a_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:11] <= MINUTES_LAST && m_tdata[22:17] <= SECONDS_LAST &&
                 m_tdata[32:23] <= MILLIS_LAST)
    else $error("count digit out of range");

  // Countdown hours come from a preset and stay small
  a_cd_hours: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[10:0] <= CD_HOURS_MAX)
    else $error("countdown hours out of range");

endmodule

bind stopwatch_countdown_timer swt_checker u_swt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/tb_stopwatch_countdown_timer.sv =====
module tb_stopwatch_countdown_timer;
  import swt_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int FIRST_PHASE_ITEMS = 100;
  localparam int PHASE_ITEMS       = 150;
  localparam int NUM_RATES         = 8;

  // Timer state tracker and queue of expected readouts
  class timer_scoreboard;
    logic [TPM_W-1:0] ticks_per_ms;
    bit               running;
    bit               paused;
    bit               stopwatch;
    bit               alert;
    logic [31:0]      count_ms;
    logic [15:0]      prescale;
    logic [28:0]      saved_preset;
    result_t          readout_q[$];
    int               mismatches;

    function new();
      ticks_per_ms = TPM_RESET;
      running      = 1'b0;
      paused       = 1'b0;
      stopwatch    = 1'b1;
      alert        = 1'b0;
      count_ms     = '0;
      prescale     = '0;
      saved_preset = '0;
      mismatches   = 0;
    endfunction

    function void set_rate(logic [TPM_W-1:0] value);
      ticks_per_ms = value;
    endfunction

    function int pending();
      return readout_q.size();
    endfunction

    // One millisecond passes: count up, count down, or raise the alarm at zero
    function void elapse_ms();
      if (stopwatch) begin
        count_ms = count_ms + 32'd1;
      end else if (count_ms == 32'd0) begin
        alert = 1'b1;
      end else begin
        count_ms = count_ms - 32'd1;
      end
    endfunction

    // Apply one command and return the readout it produces
    function result_t advance_timer(item_t it);
      logic [15:0] limit;
      logic [31:0] preset;
      logic [31:0] digit;
      result_t     r;
      limit = (ticks_per_ms == '0) ? 16'd1 : ticks_per_ms;
      case (it.cmd)
        CMD_TICK: begin
          if (running && !alert) begin
            prescale = prescale + 16'd1;
            if (prescale >= limit) begin
              prescale = '0;
              elapse_ms();
            end
          end
        end
        CMD_START: begin
          if (!running) begin
            prescale = '0;
            if (!stopwatch && count_ms == 32'd0) stopwatch = 1'b1;
            if (stopwatch) begin
              if (!paused) count_ms = '0;
            end else if (!paused) begin
              saved_preset = count_ms[28:0];
            end
            running = 1'b1;
            paused  = 1'b0;
          end
        end
        CMD_STOP: begin
          if (running) begin
            if (!stopwatch && alert) count_ms = {3'b000, saved_preset};
            running = 1'b0;
            paused  = 1'b1;
          end else begin
            count_ms  = '0;
            stopwatch = 1'b1;
            paused    = 1'b0;
          end
          alert = 1'b0;
        end
        default: begin
          preset = ((32'(it.set_hours) * 32'd60 + 32'(it.set_minutes)) * 32'd60
                    + 32'(it.set_seconds)) * 32'd1000 + 32'(it.set_millis);
          if (!running) begin
            paused = 1'b0;
            if (preset != 32'd0) begin
              stopwatch = 1'b0;
              count_ms  = preset;
            end else begin
              stopwatch = 1'b1;
              count_ms  = '0;
            end
          end
        end
      endcase
      digit             = count_ms / 32'd3600000;
      r.count.hours     = digit[HOURS_W-1:0];
      digit             = (count_ms / 32'd60000) % 32'd60;
      r.count.minutes   = digit[MINUTES_W-1:0];
      digit             = (count_ms / 32'd1000) % 32'd60;
      r.count.seconds   = digit[SECONDS_W-1:0];
      digit             = count_ms % 32'd1000;
      r.count.millis    = digit[MILLIS_W-1:0];
      r.is_running      = running;
      r.is_countdown    = !stopwatch;
      r.alarm           = alert;
      return r;
    endfunction

    function void note_command(item_t it);
      readout_q.push_back(advance_timer(it));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("readout mismatch on %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_readout(result_t got);
      result_t want;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("readout beat arrived with nothing expected");
        return;
      end
      want = readout_q.pop_front();
      compare_field("show_hours", 32'(want.count.hours), 32'(got.count.hours));
      compare_field("show_minutes", 32'(want.count.minutes), 32'(got.count.minutes));
      compare_field("show_seconds", 32'(want.count.seconds), 32'(got.count.seconds));
      compare_field("show_millis", 32'(want.count.millis), 32'(got.count.millis));
      compare_field("is_running", 32'(want.is_running), 32'(got.is_running));
      compare_field("is_countdown", 32'(want.is_countdown), 32'(got.is_countdown));
      compare_field("alarm", 32'(want.alarm), 32'(got.alarm));
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [TPM_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  timer_scoreboard      sb;
  bit                   quiet = 1'b0;
  int                   sent  = 0;
  int                   stall_left = 0;
  result_t              readout_beat;
  logic [TPM_W-1:0]     rates[NUM_RATES];

  stopwatch_countdown_timer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t random_item(cmd_t cmd);
    item_t it;
    it.cmd         = cmd;
    it.set_hours   = SET_HMS_W'($urandom_range(0, 127));
    it.set_minutes = SET_HMS_W'($urandom_range(0, 127));
    it.set_seconds = SET_HMS_W'($urandom_range(0, 127));
    it.set_millis  = SET_MILLIS_W'($urandom_range(0, 1023));
    return it;
  endfunction

  // Drive one command beat and hold it until accepted
  task automatic send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, it.set_millis, it.set_seconds, it.set_minutes, it.set_hours};
    s_tuser  <= it.cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_command(it);
    sent++;
  endtask

  task automatic send_cmd(cmd_t cmd);
    send_item(random_item(cmd));
  endtask

  task automatic send_load(int h, int m, int s, int f);
    item_t it;
    it.cmd         = CMD_LOAD;
    it.set_hours   = SET_HMS_W'(h);
    it.set_minutes = SET_HMS_W'(m);
    it.set_seconds = SET_HMS_W'(s);
    it.set_millis  = SET_MILLIS_W'(f);
    send_item(it);
  endtask

  // Drop valid and wait until every readout is back and the pipe is empty
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rate(logic [TPM_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_rate(value);
  endtask

  // Hand-picked sequence, run with one tick per millisecond
  task automatic run_directed();
    send_cmd(CMD_TICK);                 // tick while idle
    send_cmd(CMD_START);                // fresh stopwatch
    repeat (3) send_cmd(CMD_TICK);
    send_cmd(CMD_START);                // ignored while running
    send_load(127, 127, 127, 1023);     // ignored while running
    send_cmd(CMD_STOP);
    send_cmd(CMD_START);                // resume keeps the count
    send_cmd(CMD_TICK);
    send_cmd(CMD_STOP);
    send_cmd(CMD_STOP);                 // clear
    send_load(127, 127, 127, 1023);     // largest preset, fields past range
    send_load(99, 99, 99, 999);
    send_load(0, 0, 0, 0);              // zero preset back to stopwatch
    send_load(0, 0, 0, 2);
    send_cmd(CMD_START);                // saves the preset
    repeat (4) send_cmd(CMD_TICK);      // reach zero, raise alarm, hold
    send_cmd(CMD_STOP);                 // restore preset on alarm
    send_cmd(CMD_START);                // resume countdown
    repeat (3) send_cmd(CMD_TICK);
    send_cmd(CMD_STOP);
    send_cmd(CMD_STOP);
    send_load(0, 0, 0, 1);
    send_cmd(CMD_START);
    send_cmd(CMD_TICK);
    send_cmd(CMD_STOP);                 // stop at zero without alarm
    send_cmd(CMD_START);                // countdown at zero turns stopwatch
    send_cmd(CMD_TICK);
    send_cmd(CMD_STOP);
  endtask

  // One random sequence: countdown run, stopwatch run, or plain noise
  task automatic run_scenario();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) send_cmd(CMD_STOP);
      it = random_item(CMD_LOAD);
      if ($urandom_range(0, 9) != 0) begin
        it.set_hours   = '0;
        it.set_minutes = '0;
        it.set_seconds = '0;
        it.set_millis  = SET_MILLIS_W'($urandom_range(0, 8));
      end
      send_item(it);
      send_cmd(CMD_START);
      repeat ($urandom_range(0, 25)) send_cmd(CMD_TICK);
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(CMD_STOP);
        send_cmd(CMD_START);
      end
      if ($urandom_range(0, 4) == 0) send_cmd(CMD_LOAD);
      repeat ($urandom_range(0, 25)) send_cmd(CMD_TICK);
      send_cmd(CMD_STOP);
      if ($urandom_range(0, 1) == 0) send_cmd(CMD_START);
    end else if (pick < 75) begin
      if ($urandom_range(0, 1) == 0) send_cmd(CMD_STOP);
      send_cmd(CMD_START);
      repeat ($urandom_range(0, 30)) send_cmd(CMD_TICK);
      send_cmd(CMD_STOP);
      if ($urandom_range(0, 1) == 0) begin
        send_cmd(CMD_START);
        repeat ($urandom_range(0, 15)) send_cmd(CMD_TICK);
        send_cmd(CMD_STOP);
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_cmd(cmd_t'($urandom_range(0, 3)));
    end
  endtask

  // Output side: random backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29)
                                                : $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Check every accepted readout beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      readout_beat.count.hours   = m_tdata[10:0];
      readout_beat.count.minutes = m_tdata[16:11];
      readout_beat.count.seconds = m_tdata[22:17];
      readout_beat.count.millis  = m_tdata[32:23];
      readout_beat.is_running    = m_tuser[0];
      readout_beat.is_countdown  = m_tuser[1];
      readout_beat.alarm         = m_tuser[2];
      sb.check_readout(readout_beat);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("stopwatch_countdown_timer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int target;
    sb    = new();
    rates = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd65535, 16'd1, 16'd1000};
    rates[6] = TPM_W'($urandom_range(1, 20));
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // run a while at the reset prescaler value
    while (sent < FIRST_PHASE_ITEMS) run_scenario();
    settle_idle();
    write_rate(16'd1);
    run_directed();

    // random phases across prescaler settings
    for (int i = 0; i < NUM_RATES; i++) begin
      settle_idle();
      write_rate(rates[i]);
      quiet  = (i == 2) || (i == 4);
      target = sent + PHASE_ITEMS;
      while (sent < target) run_scenario();
    end
    quiet = 1'b0;
    settle_idle();

    if (sb.mismatches == 0) begin
      $display("stopwatch_countdown_timer regression: pass");
    end else begin
      $display("stopwatch_countdown_timer regression: fail");
    end
    $finish;
  end

endmodule

// ===== stopwatch_countdown_timer.f =====
design/swt_pkg.sv
design/swt_in_stage.sv
design/swt_core.sv
design/swt_out_stage.sv
design/stopwatch_countdown_timer.sv
design/swt_checker.sv
verif/tb_stopwatch_countdown_timer.sv
